// File: hdl/ifd_pkg.sv
// Shared types and constants of the information frame deframer.
`timescale 1ns / 1ps

package ifd_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7e;
  localparam logic [7:0] ESC_BYTE    = 8'h7d;
  localparam logic [7:0] ESC_OF_ESC  = 8'h5d;
  localparam logic [7:0] ESC_OF_FLAG = 8'h5e;
  localparam logic       SEQ_BIT     = 1'b1;

  localparam int unsigned CountW = 13;
  localparam int unsigned SizeW  = 12;

  localparam logic [CountW-1:0] MAX_STUFFED_BYTES = 13'd4101;
  localparam logic [CountW-1:0] COUNT_MAX         = 13'h1fff;
  localparam logic [SizeW-1:0]  MIN_FRAME_SIZE    = 12'd30;

  // Configuration register indexes.
  localparam logic [1:0] REG_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_ACK_CODE   = 2'd1;
  localparam logic [1:0] REG_NAK_CODE   = 2'd2;
  localparam logic [1:0] REG_FRAME_SIZE = 2'd3;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NEW = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]        address_byte;
    logic [7:0]        ack_code;
    logic [7:0]        nak_code;
    logic [CountW-1:0] stuffed_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              frame_end;
    logic [1:0]        verdict;
    logic [7:0]        reply_code;
    logic [CountW-1:0] payload_length;
  } result_t;

endpackage

// File: hdl/ifd_cfg_regs.sv
// Configuration registers and the derived stuffed byte limit.
`timescale 1ns / 1ps

module ifd_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [11:0]            cfg_data_i,
  output ifd_pkg::cfg_t          cfg_o
);

  logic [7:0]  address_q, address_d;
  logic [7:0]  ack_q, ack_d;
  logic [7:0]  nak_q, nak_d;
  logic [11:0] size_q, size_d;
  logic [11:0] size_clamped;
  logic [13:0] limit_wide;

  always_comb begin
    address_d = address_q;
    ack_d     = ack_q;
    nak_d     = nak_q;
    size_d    = size_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ifd_pkg::REG_ADDRESS:    address_d = cfg_data_i[7:0];
        ifd_pkg::REG_ACK_CODE:   ack_d     = cfg_data_i[7:0];
        ifd_pkg::REG_NAK_CODE:   nak_d     = cfg_data_i[7:0];
        ifd_pkg::REG_FRAME_SIZE: size_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= 8'd3;
      ack_q     <= 8'd5;
      nak_q     <= 8'd1;
      size_q    <= 12'd256;
    end else begin
      address_q <= address_d;
      ack_q     <= ack_d;
      nak_q     <= nak_d;
      size_q    <= size_d;
    end
  end

  // Limit is twice the clamped frame size plus five, capped at the hard maximum.
  assign size_clamped = (size_q < ifd_pkg::MIN_FRAME_SIZE) ? ifd_pkg::MIN_FRAME_SIZE : size_q;
  assign limit_wide   = {1'b0, size_clamped, 1'b0} + 14'd5;

  always_comb begin
    cfg_o.address_byte = address_q;
    cfg_o.ack_code     = ack_q;
    cfg_o.nak_code     = nak_q;
    if (limit_wide > {1'b0, ifd_pkg::MAX_STUFFED_BYTES}) begin
      cfg_o.stuffed_limit = ifd_pkg::MAX_STUFFED_BYTES;
    end else begin
      cfg_o.stuffed_limit = limit_wide[12:0];
    end
  end

endmodule

// File: hdl/ifd_in_reg.sv
// Input register stage holding one received link byte.
`timescale 1ns / 1ps

module ifd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       stage_valid_o,
  output logic [7:0] stage_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_byte_o  = byte_q;

endmodule

// File: hdl/ifd_core.sv
// Frame state machine: header checks, unstuffing, hold-back and verdict.
`timescale 1ns / 1ps

module ifd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ifd_pkg::cfg_t      cfg_i,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output logic               res_valid_o,
  output ifd_pkg::result_t   res_o
);

  ifd_pkg::phase_e phase_q, phase_d;
  logic            exp_seq_q, exp_seq_d;
  logic            toggled_q, toggled_d;
  logic [7:0]      addr_seen_q, addr_seen_d;
  logic [7:0]      ctrl_seen_q, ctrl_seen_d;
  logic            err_q, err_d;
  logic            dup_q, dup_d;
  logic            esc_q, esc_d;
  logic [7:0]      held_byte_q, held_byte_d;
  logic            held_valid_q, held_valid_d;
  logic [7:0]      xor_q, xor_d;
  logic [12:0]     count_q, count_d;
  logic [12:0]     stuffed_q, stuffed_d;

  logic       is_flag;
  logic       data_phase;
  logic       over_limit;
  logic       push_en;
  logic [7:0] push_val;
  logic       emit_byte;
  logic       close_frame;
  logic       bad;

  assign is_flag     = (byte_i == ifd_pkg::FLAG_BYTE);
  assign data_phase  = step_i && (phase_q == ifd_pkg::PH_DATA);
  assign over_limit  = (stuffed_q >= cfg_i.stuffed_limit);
  assign close_frame = data_phase && is_flag;
  assign emit_byte   = push_en && held_valid_q;
  assign bad         = err_q || esc_q || !held_valid_q || (held_byte_q != xor_q);

  // Payload byte decode: which unstuffed byte, if any, enters the hold register.
  always_comb begin
    push_en  = 1'b0;
    push_val = byte_i;
    if (data_phase && !is_flag && !over_limit) begin
      if (esc_q) begin
        if (byte_i == ifd_pkg::ESC_OF_ESC) begin
          push_en  = 1'b1;
          push_val = ifd_pkg::ESC_BYTE;
        end else if (byte_i == ifd_pkg::ESC_OF_FLAG) begin
          push_en  = 1'b1;
          push_val = ifd_pkg::FLAG_BYTE;
        end
      end else if (byte_i != ifd_pkg::ESC_BYTE) begin
        push_en = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    exp_seq_d    = exp_seq_q;
    toggled_d    = toggled_q;
    addr_seen_d  = addr_seen_q;
    ctrl_seen_d  = ctrl_seen_q;
    err_d        = err_q;
    dup_d        = dup_q;
    esc_d        = esc_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    xor_d        = xor_q;
    count_d      = count_q;
    stuffed_d    = stuffed_q;
    if (step_i) begin
      unique case (phase_q)
        ifd_pkg::PH_HUNT: begin
          if (is_flag) phase_d = ifd_pkg::PH_ADDR;
        end
        ifd_pkg::PH_ADDR: begin
          if (byte_i == cfg_i.address_byte) begin
            addr_seen_d = byte_i;
            phase_d     = ifd_pkg::PH_CTRL;
          end else begin
            err_d = 1'b1;
            if (toggled_q) begin
              exp_seq_d = exp_seq_q ^ ifd_pkg::SEQ_BIT;
              toggled_d = 1'b0;
            end
            dup_d   = 1'b0;
            phase_d = is_flag ? ifd_pkg::PH_ADDR : ifd_pkg::PH_HUNT;
          end
        end
        ifd_pkg::PH_CTRL: begin
          ctrl_seen_d = byte_i;
          if (byte_i == {7'd0, exp_seq_q}) begin
            exp_seq_d = exp_seq_q ^ ifd_pkg::SEQ_BIT;
            toggled_d = 1'b1;
          end else begin
            dup_d = 1'b1;
          end
          phase_d = ifd_pkg::PH_HCHK;
        end
        ifd_pkg::PH_HCHK: begin
          if (byte_i == (addr_seen_q ^ ctrl_seen_q)) begin
            phase_d      = ifd_pkg::PH_DATA;
            held_valid_d = 1'b0;
            xor_d        = 8'd0;
            count_d      = '0;
            stuffed_d    = '0;
            esc_d        = 1'b0;
          end else begin
            err_d = 1'b1;
            if (toggled_q) begin
              exp_seq_d = exp_seq_q ^ ifd_pkg::SEQ_BIT;
              toggled_d = 1'b0;
            end
            dup_d   = 1'b0;
            phase_d = is_flag ? ifd_pkg::PH_ADDR : ifd_pkg::PH_HUNT;
          end
        end
        ifd_pkg::PH_DATA: begin
          if (!is_flag) begin
            if (over_limit) begin
              err_d = 1'b1;
            end else begin
              stuffed_d = stuffed_q + 13'd1;
              if (esc_q) begin
                esc_d = 1'b0;
                if (!push_en) err_d = 1'b1;
              end else if (byte_i == ifd_pkg::ESC_BYTE) begin
                esc_d = 1'b1;
              end
            end
          end else begin
            if (bad && toggled_q) exp_seq_d = exp_seq_q ^ ifd_pkg::SEQ_BIT;
            phase_d      = ifd_pkg::PH_HUNT;
            toggled_d    = 1'b0;
            err_d        = 1'b0;
            dup_d        = 1'b0;
            esc_d        = 1'b0;
            held_valid_d = 1'b0;
            xor_d        = 8'd0;
            count_d      = '0;
            stuffed_d    = '0;
          end
        end
        default: phase_d = ifd_pkg::PH_HUNT;
      endcase
    end
    // The previously held byte goes out as the new one takes its place.
    if (push_en) begin
      held_byte_d  = push_val;
      held_valid_d = 1'b1;
      if (held_valid_q) begin
        xor_d = xor_q ^ held_byte_q;
        if (count_q != ifd_pkg::COUNT_MAX) count_d = count_q + 13'd1;
      end
    end
  end

  // Result of this step.
  always_comb begin
    res_valid_o          = emit_byte || close_frame;
    res_o.out_byte       = 8'd0;
    res_o.byte_valid     = 1'b0;
    res_o.frame_end      = 1'b0;
    res_o.verdict        = ifd_pkg::VERDICT_NEW;
    res_o.reply_code     = 8'd0;
    res_o.payload_length = '0;
    if (emit_byte) begin
      res_o.out_byte   = held_byte_q;
      res_o.byte_valid = 1'b1;
    end else if (close_frame) begin
      res_o.frame_end      = 1'b1;
      res_o.payload_length = count_q;
      if (bad) begin
        res_o.verdict    = ifd_pkg::VERDICT_ERR;
        res_o.reply_code = cfg_i.nak_code;
      end else begin
        res_o.verdict    = dup_q ? ifd_pkg::VERDICT_DUP : ifd_pkg::VERDICT_NEW;
        res_o.reply_code = cfg_i.ack_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ifd_pkg::PH_HUNT;
      exp_seq_q    <= 1'b0;
      toggled_q    <= 1'b0;
      addr_seen_q  <= 8'd0;
      ctrl_seen_q  <= 8'd0;
      err_q        <= 1'b0;
      dup_q        <= 1'b0;
      esc_q        <= 1'b0;
      held_valid_q <= 1'b0;
      xor_q        <= 8'd0;
      count_q      <= '0;
      stuffed_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      exp_seq_q    <= exp_seq_d;
      toggled_q    <= toggled_d;
      addr_seen_q  <= addr_seen_d;
      ctrl_seen_q  <= ctrl_seen_d;
      err_q        <= err_d;
      dup_q        <= dup_d;
      esc_q        <= esc_d;
      held_valid_q <= held_valid_d;
      xor_q        <= xor_d;
      count_q      <= count_d;
      stuffed_q    <= stuffed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_byte_q <= held_byte_d;
  end

endmodule

// File: hdl/ifd_out_reg.sv
// Output register holding one result until the receiver takes it.
`timescale 1ns / 1ps

module ifd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ifd_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ifd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ifd_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hdl/info_frame_deframer.sv
// Top level of the byte-stuffed information frame receiver.
//
// Link bytes enter on the rx channel (in_valid_i / in_ready_o / rx_byte_i).
// Results leave on the out channel (out_valid_o / out_ready_i): either one
// unstuffed payload byte (byte_valid_o) or a frame end carrying the verdict,
// reply code and payload length. Each byte is passed on one byte late, so the
// trailing check byte of a frame never appears as payload.
// One byte is taken every cycle while the output register is free. A byte is
// registered in the input register at its transfer; once the output register
// is free, the frame state logic processes it and its result, if any, is
// loaded into the output register, which raises out_valid_o and holds the
// result until it is taken. The input register and the output register
// decouple the two sides, so a new byte is taken while a result still waits.
// When the receiver stalls with the output register full, the input register
// fills and in_ready_o drops.
// Reset restores the register defaults (address 3, ack 5, nak 1, frame size
// 256), clears the sequence bit and starts hunting for an opening flag.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i,
// one register per cycle, while no bytes are in flight.
`timescale 1ns / 1ps

module info_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        frame_end_o,
  output logic [1:0]  verdict_o,
  output logic [7:0]  reply_code_o,
  output logic [12:0] payload_length_o
);

  ifd_pkg::cfg_t    cfg;
  ifd_pkg::result_t core_res;
  ifd_pkg::result_t out_res;
  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             out_free;
  logic             advance;
  logic             core_res_valid;

  assign advance = stage_valid && out_free;

  ifd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ifd_in_reg u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_byte_o  (stage_byte)
  );

  ifd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .byte_i      (stage_byte),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  ifd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && core_res_valid),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_byte_o       = out_res.out_byte;
  assign byte_valid_o     = out_res.byte_valid;
  assign frame_end_o      = out_res.frame_end;
  assign verdict_o        = out_res.verdict;
  assign reply_code_o     = out_res.reply_code;
  assign payload_length_o = out_res.payload_length;

endmodule

// File: hdl/ifd_checker.sv
// Port-level checks of the frame receiver and their binding to the top level.
`timescale 1ns / 1ps

module ifd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        byte_valid_o,
  input logic        frame_end_o,
  input logic [1:0]  verdict_o,
  input logic [12:0] payload_length_o
);

  // A result is exactly one of payload byte or frame end.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o != frame_end_o))
    else $error("result is neither or both of byte and frame end");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (verdict_o <= ifd_pkg::VERDICT_ERR))
    else $error("undefined verdict code");

  a_byte_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |->
      (payload_length_o == 13'd0 && verdict_o == ifd_pkg::VERDICT_NEW))
    else $error("frame end fields set on a payload byte");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(frame_end_o)))
    else $error("stalled result changed");

endmodule

bind info_frame_deframer ifd_checker u_ifd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_byte_o       (out_byte_o),
  .byte_valid_o     (byte_valid_o),
  .frame_end_o      (frame_end_o),
  .verdict_o        (verdict_o),
  .payload_length_o (payload_length_o)
);

// File: test/info_frame_deframer_test.sv
// Self-checking testbench of the information frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module info_frame_deframer_test;

  localparam int PhaseCount   = 6;
  localparam int PhaseBytes   = 320;
  localparam int SettleCycles = 6;
  localparam int CycleLimit   = 500000;

  localparam ifd_pkg::result_t NoResult = '0;

  typedef struct {
    logic [7:0]       rx;
    bit               typed;
    bit               has_result;
    ifd_pkg::result_t result;
  } link_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ifd_pkg::REG_ADDRESS;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        frame_end;
  logic [1:0]  verdict;
  logic [7:0]  reply_code;
  logic [12:0] payload_length;

  // Mirror of the registers and of the frame state, advanced once per accepted link byte.
  logic [7:0]      cfg_address = 8'd3;
  logic [7:0]      cfg_ack = 8'd5;
  logic [7:0]      cfg_nak = 8'd1;
  logic [11:0]     cfg_frame_size = 12'd256;
  ifd_pkg::phase_e rx_phase = ifd_pkg::PH_HUNT;
  logic            seq_expected = 1'b0;
  logic            seq_flipped = 1'b0;
  logic [7:0]      addr_rcvd = '0;
  logic [7:0]      ctrl_rcvd = '0;
  logic            error_seen = 1'b0;
  logic            dup_seen = 1'b0;
  logic            escape_open = 1'b0;
  logic [7:0]      held_byte = '0;
  logic            held_full = 1'b0;
  logic [7:0]      running_xor = '0;
  logic [12:0]     delivered = '0;
  int              stuffed_seen = 0;

  ifd_pkg::result_t deframed_results[$];
  logic [7:0]       frame_bytes[$];
  link_row_t        directed_rows[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               stall_left = 0;
  bit               idle_on = 1'b1;

  info_frame_deframer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_o       (out_byte),
    .byte_valid_o     (byte_valid),
    .frame_end_o      (frame_end),
    .verdict_o        (verdict),
    .reply_code_o     (reply_code),
    .payload_length_o (payload_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ifd_pkg::result_t byte_result(input logic [7:0] v);
    ifd_pkg::result_t r;
    r = NoResult;
    r.out_byte = v;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic ifd_pkg::result_t end_result(input logic [1:0] v, input logic [7:0] code,
                                                  input logic [12:0] len);
    ifd_pkg::result_t r;
    r = NoResult;
    r.frame_end = 1'b1;
    r.verdict = v;
    r.reply_code = code;
    r.payload_length = len;
    return r;
  endfunction

  function automatic string describe(input ifd_pkg::result_t r);
    return $sformatf("byte %02h valid %0b end %0b verdict %0d reply %02h length %0d",
                     r.out_byte, r.byte_valid, r.frame_end, r.verdict, r.reply_code,
                     r.payload_length);
  endfunction

  function automatic int stuffing_limit();
    int fs;
    int lim;
    fs = cfg_frame_size;
    if (fs < ifd_pkg::MIN_FRAME_SIZE) fs = ifd_pkg::MIN_FRAME_SIZE;
    lim = 2 * fs + 5;
    if (lim > ifd_pkg::MAX_STUFFED_BYTES) lim = ifd_pkg::MAX_STUFFED_BYTES;
    return lim;
  endfunction

  // A failed header gives back the sequence bit only if this attempt took it.
  function automatic void abandon_header();
    if (seq_flipped) begin
      seq_expected ^= ifd_pkg::SEQ_BIT;
      seq_flipped = 1'b0;
    end
    dup_seen = 1'b0;
  endfunction

  function automatic void clear_payload();
    held_full = 1'b0;
    held_byte = '0;
    running_xor = '0;
    delivered = '0;
    stuffed_seen = 0;
    escape_open = 1'b0;
  endfunction

  // Each unstuffed byte is held back by one, so the check byte stays behind at the flag.
  function automatic bit pass_on(input logic [7:0] v, output ifd_pkg::result_t res);
    bit produced;
    res = NoResult;
    produced = held_full;
    if (held_full) begin
      res.out_byte = held_byte;
      res.byte_valid = 1'b1;
      running_xor ^= held_byte;
      if (delivered != ifd_pkg::COUNT_MAX) delivered++;
    end
    held_byte = v;
    held_full = 1'b1;
    return produced;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output ifd_pkg::result_t res);
    bit bad;
    res = NoResult;
    case (rx_phase)
      ifd_pkg::PH_HUNT: begin
        if (b == ifd_pkg::FLAG_BYTE) rx_phase = ifd_pkg::PH_ADDR;
        return 1'b0;
      end
      ifd_pkg::PH_ADDR: begin
        if (b == cfg_address) begin
          addr_rcvd = b;
          rx_phase = ifd_pkg::PH_CTRL;
        end else begin
          error_seen = 1'b1;
          abandon_header();
          rx_phase = (b == ifd_pkg::FLAG_BYTE) ? ifd_pkg::PH_ADDR : ifd_pkg::PH_HUNT;
        end
        return 1'b0;
      end
      ifd_pkg::PH_CTRL: begin
        ctrl_rcvd = b;
        if (b == {7'd0, seq_expected}) begin
          seq_expected ^= ifd_pkg::SEQ_BIT;
          seq_flipped = 1'b1;
        end else begin
          dup_seen = 1'b1;
        end
        rx_phase = ifd_pkg::PH_HCHK;
        return 1'b0;
      end
      ifd_pkg::PH_HCHK: begin
        if (b == (addr_rcvd ^ ctrl_rcvd)) begin
          rx_phase = ifd_pkg::PH_DATA;
          clear_payload();
        end else begin
          error_seen = 1'b1;
          abandon_header();
          rx_phase = (b == ifd_pkg::FLAG_BYTE) ? ifd_pkg::PH_ADDR : ifd_pkg::PH_HUNT;
        end
        return 1'b0;
      end
      ifd_pkg::PH_DATA: begin
        if (b != ifd_pkg::FLAG_BYTE) begin
          if (stuffed_seen >= stuffing_limit()) begin
            error_seen = 1'b1;
            return 1'b0;
          end
          stuffed_seen++;
          if (escape_open) begin
            escape_open = 1'b0;
            if (b == ifd_pkg::ESC_OF_ESC) return pass_on(ifd_pkg::ESC_BYTE, res);
            if (b == ifd_pkg::ESC_OF_FLAG) return pass_on(ifd_pkg::FLAG_BYTE, res);
            error_seen = 1'b1;
            return 1'b0;
          end
          if (b == ifd_pkg::ESC_BYTE) begin
            escape_open = 1'b1;
            return 1'b0;
          end
          return pass_on(b, res);
        end
        bad = error_seen || escape_open || !held_full || (held_byte != running_xor);
        res.frame_end = 1'b1;
        res.payload_length = delivered;
        if (bad) begin
          res.verdict = ifd_pkg::VERDICT_ERR;
          res.reply_code = cfg_nak;
          if (seq_flipped) seq_expected ^= ifd_pkg::SEQ_BIT;
        end else begin
          res.verdict = dup_seen ? ifd_pkg::VERDICT_DUP : ifd_pkg::VERDICT_NEW;
          res.reply_code = cfg_ack;
        end
        rx_phase = ifd_pkg::PH_HUNT;
        seq_flipped = 1'b0;
        error_seen = 1'b0;
        dup_seen = 1'b0;
        clear_payload();
        return 1'b1;
      end
      default: begin
        rx_phase = ifd_pkg::PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] link_noise();
    case ($urandom_range(0, 7))
      0: return ifd_pkg::FLAG_BYTE;
      1: return ifd_pkg::ESC_BYTE;
      2: return ifd_pkg::ESC_OF_ESC;
      3: return ifd_pkg::ESC_OF_FLAG;
      4: return cfg_address;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] payload_value();
    case ($urandom_range(0, 9))
      0: return ifd_pkg::FLAG_BYTE;
      1: return ifd_pkg::ESC_BYTE;
      2: return 8'h00;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic stuff_byte(input logic [7:0] v);
    if (v == ifd_pkg::FLAG_BYTE) begin
      frame_bytes.push_back(ifd_pkg::ESC_BYTE);
      frame_bytes.push_back(ifd_pkg::ESC_OF_FLAG);
    end else if (v == ifd_pkg::ESC_BYTE) begin
      frame_bytes.push_back(ifd_pkg::ESC_BYTE);
      frame_bytes.push_back(ifd_pkg::ESC_OF_ESC);
    end else begin
      frame_bytes.push_back(v);
    end
  endtask

  // Mostly well-formed frames with random content; some noise, broken headers and bad payloads.
  task automatic queue_frame();
    logic [7:0] ctrl;
    logic [7:0] check;
    logic [7:0] v;
    int n;
    int pick;
    int limit;
    int i;
    limit = stuffing_limit();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(link_noise());
      return;
    end
    frame_bytes.push_back(ifd_pkg::FLAG_BYTE);
    frame_bytes.push_back(($urandom_range(0, 19) == 0) ? link_noise() : cfg_address);
    pick = $urandom_range(0, 9);
    if (pick < 7) ctrl = {7'd0, seq_expected};
    else if (pick == 7) ctrl = {7'd0, ~seq_expected};
    else if (pick == 8) ctrl = ifd_pkg::FLAG_BYTE;
    else ctrl = 8'($urandom);
    frame_bytes.push_back(ctrl);
    frame_bytes.push_back(($urandom_range(0, 19) == 0) ? link_noise() : (cfg_address ^ ctrl));
    pick = $urandom_range(0, 99);
    // A header with nothing behind it: the next opening flag closes this frame.
    if (pick < 3) return;
    if (pick < 7) begin
      n = 0;
    end else if (pick < 82) begin
      n = $urandom_range(1, 12);
    end else if (pick < 95) begin
      n = $urandom_range(13, 48);
    end else if (limit <= 300) begin
      // Oversize frames only where the limit is small enough to reach cheaply.
      n = limit + $urandom_range(1, 8);
    end else begin
      n = $urandom_range(49, 120);
    end
    check = '0;
    for (i = 0; i < n; i++) begin
      v = payload_value();
      check ^= v;
      stuff_byte(v);
    end
    if (n > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) check ^= 8'($urandom_range(1, 255));
      stuff_byte(check);
      if (pick >= 5 && pick < 9) begin
        v = 8'($urandom);
        while (v == ifd_pkg::ESC_OF_ESC || v == ifd_pkg::ESC_OF_FLAG) v = 8'($urandom);
        frame_bytes.push_back(ifd_pkg::ESC_BYTE);
        frame_bytes.push_back(v);
      end else if (pick >= 9 && pick < 12) begin
        frame_bytes.push_back(ifd_pkg::ESC_BYTE);
      end
    end
    frame_bytes.push_back(ifd_pkg::FLAG_BYTE);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      ifd_pkg::REG_ADDRESS:    cfg_address = value[7:0];
      ifd_pkg::REG_ACK_CODE:   cfg_ack = value[7:0];
      ifd_pkg::REG_NAK_CODE:   cfg_nak = value[7:0];
      ifd_pkg::REG_FRAME_SIZE: cfg_frame_size = value;
      default: ;
    endcase
  endtask

  // Valid stays high across back-to-back transfers; it only drops for a gap or at the end.
  task automatic send_link_byte(input logic [7:0] b, input bit typed, input bit has_result,
                                input ifd_pkg::result_t typed_result);
    ifd_pkg::result_t predicted;
    bit produced;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = deframe_byte(b, predicted);
    if (typed) begin
      if (has_result) deframed_results.push_back(typed_result);
    end else if (produced) begin
      deframed_results.push_back(predicted);
    end
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (deframed_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_ready
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    ifd_pkg::result_t got;
    ifd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte, byte_valid, frame_end, verdict, reply_code, payload_length};
      if (deframed_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result: %s", describe(got));
        mismatch_count++;
      end else begin
        want = deframed_results.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.frame_end !== want.frame_end || got.verdict !== want.verdict ||
            got.reply_code !== want.reply_code ||
            got.payload_length !== want.payload_length) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected %s", describe(want));
            $display("          got      %s", describe(got));
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  addr;
    logic [7:0]  ack;
    logic [7:0]  nak;
    logic [11:0] fsize;
    int          sent;
    int          p;

    // Stray byte, then a clean frame with one payload byte under the reset registers.
    directed_rows.push_back('{8'h00, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h7e, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h03, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h00, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h03, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h41, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h41, 1'b1, 1'b1, byte_result(8'h41)});
    directed_rows.push_back('{8'h7e, 1'b1, 1'b1,
                              end_result(ifd_pkg::VERDICT_NEW, 8'd5, 13'd1)});
    // Repeated sequence bit, both escape codes, byte extremes and a bad escape.
    directed_rows.push_back('{8'h7e, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h03, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h03, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h7d, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h5e, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h7d, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h5d, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'hff, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h7d, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h41, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h00, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h7e, 1'b0, 1'b0, NoResult});
    // Wrong address; its error carries over to the following empty frame.
    directed_rows.push_back('{8'h7e, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h55, 1'b0, 1'b0, NoResult});
    directed_rows.push_back('{8'h7e, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h03, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h01, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h02, 1'b1, 1'b0, NoResult});
    directed_rows.push_back('{8'h7e, 1'b1, 1'b1,
                              end_result(ifd_pkg::VERDICT_ERR, 8'd1, 13'd0)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_link_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].has_result,
                     directed_rows[i].result);
    end
    drain_phase();

    for (p = 0; p < PhaseCount; p++) begin
      idle_on = (p != PhaseCount - 1);
      addr = 8'($urandom);
      ack = 8'($urandom);
      nak = 8'($urandom);
      fsize = 12'($urandom);
      case (p)
        0: begin
          addr = 8'h00; ack = 8'hff; nak = 8'h00; fsize = 12'd30;
        end
        1: begin
          addr = 8'hff; ack = 8'h00; nak = 8'hff; fsize = 12'hfff;
        end
        2: begin
          addr = ifd_pkg::FLAG_BYTE; ack = 8'ha5; nak = 8'h5a; fsize = 12'd0;
        end
        3: begin
          addr = ifd_pkg::ESC_BYTE; fsize = 12'd2048;
        end
        4: fsize = 12'd100;
        default: ;
      endcase
      // The unused upper data bits of the byte-wide registers get random values.
      write_register(ifd_pkg::REG_ADDRESS, {4'($urandom), addr});
      write_register(ifd_pkg::REG_ACK_CODE, {4'($urandom), ack});
      write_register(ifd_pkg::REG_NAK_CODE, {4'($urandom), nak});
      write_register(ifd_pkg::REG_FRAME_SIZE, fsize);
      cfg_we <= 1'b0;
      sent = 0;
      while (sent < PhaseBytes) begin
        queue_frame();
        while (frame_bytes.size() != 0) begin
          send_link_byte(frame_bytes.pop_front(), 1'b0, 1'b0, NoResult);
          sent++;
        end
      end
      drain_phase();
    end

    if (mismatch_count == 0 && deframed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ifd_pkg.sv
hdl/ifd_cfg_regs.sv
hdl/ifd_in_reg.sv
hdl/ifd_core.sv
hdl/ifd_out_reg.sv
hdl/info_frame_deframer.sv
hdl/ifd_checker.sv
test/info_frame_deframer_test.sv
